// ===== rtl/core/crmr_pkg.sv =====
// Shared types and constants of the CAN rule-match responder.
// No dependencies; every other file of the block refers to it by scoped names.
package crmr_pkg;

    // Default sizes of the rule table
    localparam int NUM_RULES_DEF     = 16;
    localparam int RESP_PER_RULE_DEF = 8;

    // Field widths fixed by the interface
    localparam int CMD_W   = 2;
    localparam int RIDX_W  = 4;
    localparam int SIDX_W  = 3;
    localparam int ID_W    = 29;
    localparam int LEN_W   = 4;
    localparam int DATA_W  = 64;
    localparam int CNT_W   = 4;
    localparam int HIT_W   = 4;

    // Longest run of response frames and the widest prefix, in bytes
    localparam int MAX_RUN      = 8;
    localparam int PREFIX_BYTES = 8;

    // Job fields wide enough for a table of up to 64 rules x 64 slots
    localparam int JOB_RULE_W = 6;
    localparam int JOB_SLOT_W = 12;

    // Command codes of an input beat
    localparam logic [CMD_W-1:0] CMD_HEADER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SLOT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FRAME  = 2'd2;

    typedef enum logic {
        JOB_WRITE,
        JOB_RUN
    } t_job_kind;

    // Work handed from the front end to the back end
    typedef struct packed {
        t_job_kind               kind;
        logic [JOB_RULE_W-1:0]   rule;
        logic [CNT_W-1:0]        count;
        logic [JOB_SLOT_W-1:0]   slot;
        logic [ID_W-1:0]         id;
        logic [LEN_W-1:0]        dlc;
        logic [DATA_W-1:0]       data;
    } t_job;

endpackage

// ===== rtl/core/can_rule_match_responder_unit.sv =====
// Top level of the CAN rule-match responder.
// Depends on crmr_pkg, crmr_front, crmr_queue and crmr_back.

// Answers CAN requests from a table of rules. A header load, an unused command and a frame
// that arrives while the channel is closed are taken without entering the front-end stage,
// and the next beat can follow at once. A response-slot load or a frame on the open channel
// is held in that stage. There the frame, already compared against all rule headers in
// parallel, has its first hit picked and passed on. The next beat therefore waits until the
// stage is free, and the stage stays held while the two-entry job queue is full. A header
// load takes effect at once. Slot loads and runs of responses go through the queue to the
// back end, so slot writes and slot reads stay in order. The back end reads one response
// frame per cycle from its frame memory while the result side keeps popping. A matching
// frame passes the front-end stage, the job queue and the back-end sequencer, and the
// registered memory read puts each of its results on the result ports, up to eight results
// per frame. No clearing pass after reset: response slots must be written before a rule
// that uses them is enabled.
module can_rule_match_responder_unit #(
    parameter int NUM_RULES     = crmr_pkg::NUM_RULES_DEF,
    parameter int RESP_PER_RULE = crmr_pkg::RESP_PER_RULE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic [crmr_pkg::CMD_W-1:0]  i_cmd,
    input  logic [crmr_pkg::RIDX_W-1:0] i_rule_index,
    input  logic [crmr_pkg::SIDX_W-1:0] i_slot_index,
    input  logic [crmr_pkg::ID_W-1:0]   i_frame_id,
    input  logic [crmr_pkg::LEN_W-1:0]  i_frame_len,
    input  logic [crmr_pkg::DATA_W-1:0] i_frame_data,
    input  logic [crmr_pkg::CNT_W-1:0]  i_resp_count,
    output logic                        empty,
    input  logic                        pop,
    output logic [crmr_pkg::ID_W-1:0]   o_resp_id,
    output logic [crmr_pkg::LEN_W-1:0]  o_resp_dlc,
    output logic [crmr_pkg::DATA_W-1:0] o_resp_data,
    output logic [crmr_pkg::HIT_W-1:0]  o_rule_hit,
    output logic                        o_last
);

    logic           fq_valid;
    logic           fq_ready;
    crmr_pkg::t_job fq_job;
    logic           qb_valid;
    logic           qb_ready;
    crmr_pkg::t_job qb_job;

    // Accept, classify and match
    crmr_front #(
        .NUM_RULES     (NUM_RULES),
        .RESP_PER_RULE (RESP_PER_RULE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_cmd        (i_cmd),
        .i_rule_index (i_rule_index),
        .i_slot_index (i_slot_index),
        .i_frame_id   (i_frame_id),
        .i_frame_len  (i_frame_len),
        .i_frame_data (i_frame_data),
        .i_resp_count (i_resp_count),
        .o_job_valid  (fq_valid),
        .i_job_ready  (fq_ready),
        .o_job        (fq_job)
    );

    // Decouple front and back
    crmr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fq_valid),
        .o_wr_ready (fq_ready),
        .i_wr_job   (fq_job),
        .o_rd_valid (qb_valid),
        .i_rd_ready (qb_ready),
        .o_rd_job   (qb_job)
    );

    // Store response frames and play out runs
    crmr_back #(
        .NUM_RULES     (NUM_RULES),
        .RESP_PER_RULE (RESP_PER_RULE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (qb_valid),
        .o_job_ready (qb_ready),
        .i_job       (qb_job),
        .empty       (empty),
        .pop         (pop),
        .o_resp_id   (o_resp_id),
        .o_resp_dlc  (o_resp_dlc),
        .o_resp_data (o_resp_data),
        .o_rule_hit  (o_rule_hit),
        .o_last      (o_last)
    );

endmodule

// ===== rtl/core/crmr_front.sv =====
// Front end: accepts input beats, holds the rule headers, matches frames.
// Depends on crmr_pkg; hands response-slot writes and response runs on as jobs.
module crmr_front #(
    parameter int NUM_RULES     = crmr_pkg::NUM_RULES_DEF,
    parameter int RESP_PER_RULE = crmr_pkg::RESP_PER_RULE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [crmr_pkg::CMD_W-1:0]    i_cmd,
    input  logic [crmr_pkg::RIDX_W-1:0]   i_rule_index,
    input  logic [crmr_pkg::SIDX_W-1:0]   i_slot_index,
    input  logic [crmr_pkg::ID_W-1:0]     i_frame_id,
    input  logic [crmr_pkg::LEN_W-1:0]    i_frame_len,
    input  logic [crmr_pkg::DATA_W-1:0]   i_frame_data,
    input  logic [crmr_pkg::CNT_W-1:0]    i_resp_count,
    output logic                          o_job_valid,
    input  logic                          i_job_ready,
    output crmr_pkg::t_job                o_job
);

    localparam int RW        = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
    localparam int CNT_LIMIT = (RESP_PER_RULE < crmr_pkg::MAX_RUN) ?
                               RESP_PER_RULE : crmr_pkg::MAX_RUN;

    // Every prefix byte must lie within the dlc and equal the frame byte
    function automatic logic prefix_ok(
        input logic [crmr_pkg::LEN_W-1:0]  plen,
        input logic [crmr_pkg::DATA_W-1:0] want,
        input logic [crmr_pkg::LEN_W-1:0]  dlc,
        input logic [crmr_pkg::DATA_W-1:0] got
    );
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < crmr_pkg::PREFIX_BYTES; i++) begin
            if (crmr_pkg::LEN_W'(i) < plen) begin
                if (crmr_pkg::LEN_W'(i) >= dlc || want[8*i +: 8] != got[8*i +: 8]) begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

    // Rule table; the count doubles as the enable, so only it is reset
    logic [crmr_pkg::ID_W-1:0]   r_rule_id    [NUM_RULES];
    logic [crmr_pkg::LEN_W-1:0]  r_rule_plen  [NUM_RULES];
    logic [crmr_pkg::DATA_W-1:0] r_rule_bytes [NUM_RULES];
    logic [crmr_pkg::CNT_W-1:0]  r_rule_cnt   [NUM_RULES];

    logic r_chan_open;

    // Stage between accept and job issue
    logic                          r_st_valid;
    crmr_pkg::t_job_kind           r_st_kind;
    logic [NUM_RULES-1:0]          r_st_hit;
    logic [crmr_pkg::JOB_SLOT_W-1:0] r_st_slot;
    logic [crmr_pkg::ID_W-1:0]     r_st_id;
    logic [crmr_pkg::LEN_W-1:0]    r_st_dlc;
    logic [crmr_pkg::DATA_W-1:0]   r_st_data;

    logic                          accept;
    logic                          rule_ok;
    logic                          slot_ok;
    logic                          hdr_we;
    logic                          take_slot;
    logic                          take_frame;
    logic [crmr_pkg::LEN_W-1:0]    hdr_plen;
    logic [crmr_pkg::CNT_W-1:0]    hdr_cnt;
    logic [NUM_RULES-1:0]          hit_vec;
    logic [RW-1:0]                 sel;
    logic                          any_hit;
    logic                          st_done;

    assign o_cfg_ready = 1'b1;
    assign full        = r_st_valid;
    assign accept      = push && !full;

    assign rule_ok    = (32'(i_rule_index) < NUM_RULES);
    assign slot_ok    = (32'(i_slot_index) < RESP_PER_RULE);
    assign hdr_we     = accept && (i_cmd == crmr_pkg::CMD_HEADER) && rule_ok;
    assign take_slot  = accept && (i_cmd == crmr_pkg::CMD_SLOT) && rule_ok && slot_ok;
    assign take_frame = accept && (i_cmd == crmr_pkg::CMD_FRAME) && r_chan_open;

    // Saturate header prefix length and response count
    assign hdr_plen = (i_frame_len > crmr_pkg::LEN_W'(crmr_pkg::PREFIX_BYTES)) ?
                      crmr_pkg::LEN_W'(crmr_pkg::PREFIX_BYTES) : i_frame_len;
    assign hdr_cnt  = (i_resp_count > crmr_pkg::CNT_W'(CNT_LIMIT)) ?
                      crmr_pkg::CNT_W'(CNT_LIMIT) : i_resp_count;

    // Compare the incoming frame against every rule at once
    always_comb begin
        for (int r = 0; r < NUM_RULES; r++) begin
            hit_vec[r] = (r_rule_cnt[r] != '0) &&
                         (r_rule_id[r] == '0 || r_rule_id[r] == i_frame_id) &&
                         prefix_ok(r_rule_plen[r], r_rule_bytes[r], i_frame_len, i_frame_data);
        end
    end

    // Pick the lowest-numbered rule that hit
    always_comb begin
        sel = '0;
        for (int r = NUM_RULES - 1; r >= 0; r--) begin
            if (r_st_hit[r]) begin
                sel = RW'(r);
            end
        end
    end

    assign any_hit = |r_st_hit;

    // Build the job from the held beat
    always_comb begin
        o_job = '0;
        o_job.kind = r_st_kind;
        o_job.id   = r_st_id;
        o_job.dlc  = r_st_dlc;
        o_job.data = r_st_data;
        if (r_st_kind == crmr_pkg::JOB_RUN) begin
            o_job.rule  = crmr_pkg::JOB_RULE_W'(sel);
            o_job.count = r_rule_cnt[sel];
            o_job.slot  = crmr_pkg::JOB_SLOT_W'(32'(sel) * RESP_PER_RULE);
        end else begin
            o_job.slot  = r_st_slot;
        end
    end

    assign o_job_valid = r_st_valid && (r_st_kind == crmr_pkg::JOB_WRITE || any_hit);
    assign st_done     = (o_job_valid && i_job_ready) ||
                         (r_st_valid && r_st_kind == crmr_pkg::JOB_RUN && !any_hit);

    // Channel-open register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_open <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_chan_open <= i_cfg_data;
        end
    end

    // Rule counts: cleared by reset, written by header beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_RULES; r++) begin
                r_rule_cnt[r] <= '0;
            end
        end else begin
            for (int r = 0; r < NUM_RULES; r++) begin
                if (hdr_we && 32'(i_rule_index) == 32'(r)) begin
                    r_rule_cnt[r] <= hdr_cnt;
                end
            end
        end
    end

    // Rest of the rule header
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < NUM_RULES; r++) begin
            if (hdr_we && 32'(i_rule_index) == 32'(r)) begin
                r_rule_id[r]    <= i_frame_id;
                r_rule_plen[r]  <= hdr_plen;
                r_rule_bytes[r] <= i_frame_data;
            end
        end
    end

    // Stage valid: hold until the job leaves or the frame missed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_valid <= 1'b0;
        end else if (take_slot || take_frame) begin
            r_st_valid <= 1'b1;
        end else if (st_done) begin
            r_st_valid <= 1'b0;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (take_slot || take_frame) begin
            r_st_kind <= take_frame ? crmr_pkg::JOB_RUN : crmr_pkg::JOB_WRITE;
            r_st_hit  <= hit_vec;
            r_st_slot <= crmr_pkg::JOB_SLOT_W'(32'(i_rule_index) * RESP_PER_RULE +
                                               32'(i_slot_index));
            r_st_id   <= i_frame_id;
            r_st_dlc  <= i_frame_len;
            r_st_data <= i_frame_data;
        end
    end

endmodule

// ===== rtl/core/crmr_queue.sv =====
// Two-entry job queue between the front end and the back end.
// Depends on crmr_pkg for the job type.
module crmr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    output logic           o_wr_ready,
    input  crmr_pkg::t_job i_wr_job,
    output logic           o_rd_valid,
    input  logic           i_rd_ready,
    output crmr_pkg::t_job o_rd_job
);

    localparam int DEPTH = 2;

    crmr_pkg::t_job r_mem [DEPTH];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           wr_en;
    logic           rd_en;
    logic [1:0]     n_count;

    assign o_wr_ready = (r_count != 2'(DEPTH));
    assign o_rd_valid = (r_count != 2'd0);
    assign o_rd_job   = r_mem[r_rd_ptr];
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = o_rd_valid && i_rd_ready;

    // Next fill level
    always_comb begin
        n_count = r_count;
        if (wr_en && !rd_en) begin
            n_count = r_count + 2'd1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 2'd1;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    // Store jobs
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(DEPTH))
        else $error("job queue fill level out of range");

    a_ptrs_track_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'(DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("job queue pointers disagree with fill level");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && !rd_en) |=> (r_count == $past(r_count) + 2'd1))
        else $error("job queue lost a write");
`endif

endmodule

// ===== rtl/core/crmr_back.sv =====
// Back end: response-frame memory and the sequencer that plays out a run.
// Depends on crmr_pkg; takes jobs from the queue, drives the result beats.
module crmr_back #(
    parameter int NUM_RULES     = crmr_pkg::NUM_RULES_DEF,
    parameter int RESP_PER_RULE = crmr_pkg::RESP_PER_RULE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_valid,
    output logic                        o_job_ready,
    input  crmr_pkg::t_job              i_job,
    output logic                        empty,
    input  logic                        pop,
    output logic [crmr_pkg::ID_W-1:0]   o_resp_id,
    output logic [crmr_pkg::LEN_W-1:0]  o_resp_dlc,
    output logic [crmr_pkg::DATA_W-1:0] o_resp_data,
    output logic [crmr_pkg::HIT_W-1:0]  o_rule_hit,
    output logic                        o_last
);

    localparam int SLOTS = NUM_RULES * RESP_PER_RULE;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Response-frame memory, one write and one read port
    logic [crmr_pkg::ID_W-1:0]   r_mem_id   [SLOTS];
    logic [crmr_pkg::LEN_W-1:0]  r_mem_dlc  [SLOTS];
    logic [crmr_pkg::DATA_W-1:0] r_mem_data [SLOTS];

    logic                        r_busy;
    logic [SW-1:0]               r_addr;
    logic [crmr_pkg::CNT_W-1:0]  r_left;
    logic [crmr_pkg::HIT_W-1:0]  r_rule;
    logic                        r_out_valid;

    logic                        job_take;
    logic                        mem_we;
    logic                        rd_en;
    logic                        out_pop;

    assign o_job_ready = !r_busy;
    assign job_take    = i_job_valid && o_job_ready;
    assign mem_we      = job_take && (i_job.kind == crmr_pkg::JOB_WRITE);
    assign empty       = !r_out_valid;
    assign out_pop     = pop && r_out_valid;
    assign rd_en       = r_busy && (!r_out_valid || out_pop);

    // Sequencer: load a run, then step through its slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (job_take && i_job.kind == crmr_pkg::JOB_RUN) begin
            r_busy <= 1'b1;
        end else if (rd_en && r_left == crmr_pkg::CNT_W'(1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_take && i_job.kind == crmr_pkg::JOB_RUN) begin
            r_addr <= SW'(i_job.slot);
            r_left <= i_job.count;
            r_rule <= crmr_pkg::HIT_W'(i_job.rule);
        end else if (rd_en) begin
            r_addr <= r_addr + SW'(1);
            r_left <= r_left - crmr_pkg::CNT_W'(1);
        end
    end

    // Result beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rd_en) begin
            r_out_valid <= 1'b1;
        end else if (out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Memory write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_id[SW'(i_job.slot)]   <= i_job.id;
            r_mem_dlc[SW'(i_job.slot)]  <= i_job.dlc;
            r_mem_data[SW'(i_job.slot)] <= i_job.data;
        end
    end

    // Registered read straight into the result beat
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            o_resp_id   <= r_mem_id[r_addr];
            o_resp_dlc  <= r_mem_dlc[r_addr];
            o_resp_data <= r_mem_data[r_addr];
            o_rule_hit  <= r_rule;
            o_last      <= (r_left == crmr_pkg::CNT_W'(1));
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_left != '0))
        else $error("sequencer busy with no frames left");

    a_no_write_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> !rd_en)
        else $error("memory write during a run");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && r_left == crmr_pkg::CNT_W'(1)) |=> (!r_busy && o_last))
        else $error("run did not end on its last frame");
`endif

endmodule
